### hw/rtl/prpi_pkg.sv
// Package for the damped power-iteration ranking block.
// Holds payload structs, action codes, the state enum and fixed-point constants.
// No dependencies.
package prpi_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned RankW       = 24;
  localparam int unsigned CfgW        = 16;

  localparam logic [RankW-1:0] RankMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ActSetEdge = 2'd0,
    ActClear   = 2'd1,
    ActRun     = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CfgVertexCount = 2'd0,
    CfgNullEdge    = 2'd1,
    CfgIterCount   = 2'd2,
    CfgDamping     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StDegree,
    StSetup,
    StIter,
    StEmit
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  from_index;
    logic [3:0]  to_index;
    logic [15:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic [3:0]  vertex_index;
    logic [15:0] rank_q16;
    logic        last_rank;
  } rsp_t;

  // Controls fanned out to every cell.
  typedef struct packed {
    logic init;
    logic shift;
    logic commit;
  } cell_ctrl_t;

endpackage

### hw/rtl/prpi_div.sv
// Sequential restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
module prpi_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

### hw/rtl/prpi_cell.sv
// One vertex cell: holds previous rank, share and running sum, and shifts its
// share to the neighbor when shift is set and load_share is not. Depends on prpi_pkg.
module prpi_cell (
  input  logic                      clk_i,
  input  prpi_pkg::cell_ctrl_t      ctrl_i,
  input  logic [prpi_pkg::RankW-1:0] init_rank_i,
  input  logic [prpi_pkg::RankW-1:0] new_rank_i,
  input  logic [prpi_pkg::RankW-1:0] share_i,
  input  logic [prpi_pkg::RankW-1:0] share_load_i,
  input  logic                      load_share_i,
  input  logic                      edge_i,
  output logic [prpi_pkg::RankW-1:0] share_o,
  output logic [prpi_pkg::RankW-1:0] rank_o,
  output logic [prpi_pkg::RankW+4:0] sum_o
);

  logic [prpi_pkg::RankW-1:0] rank_q, rank_d;
  logic [prpi_pkg::RankW-1:0] share_q, share_d;
  logic [prpi_pkg::RankW+4:0] sum_q, sum_d;

  always_comb begin
    rank_d  = rank_q;
    share_d = share_q;
    sum_d   = sum_q;
    if (ctrl_i.init) begin
      rank_d = init_rank_i;
      sum_d  = '0;
    end else if (ctrl_i.commit) begin
      rank_d = new_rank_i;
      sum_d  = '0;
    end
    if (load_share_i) begin
      share_d = share_load_i;
    end else if (ctrl_i.shift) begin
      share_d = share_i;
      if (edge_i) begin
        sum_d = sum_q + {5'd0, share_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q  <= rank_d;
    share_q <= share_d;
    sum_q   <= sum_d;
  end

  assign share_o = share_q;
  assign rank_o  = rank_q;
  assign sum_o   = sum_q;

endmodule

### hw/rtl/pagerank_power_iteration.sv
// Damped power-iteration ranking over a stored adjacency bit matrix.
// Depends on prpi_pkg, prpi_cell and prpi_div.
//
// Usage: requests arrive on req_valid_i/req_stall_o with a prpi_pkg::req_t.
// A set-edge or clear request is taken while idle and produces no result;
// edge writes are accepted back to back while idle. A run request produces
// N results on rsp_valid_o/rsp_stall_i, one per vertex in order, last_rank set
// on vertex N-1. The user must write the configuration on
// cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce it.
// A run counts the out-degree of each vertex, makes two divider passes for 1/N
// and the teleport term, then per iteration makes one divider pass per vertex
// with out-edges, shifts once around the 16-cell ring, does a multiply and
// update per vertex on the shared multiplier and commits. Results then leave
// one per cycle while rsp_stall_i is low, through an output register.
// req_stall_o stays high from the run request until the last result is taken;
// while rsp_stall_i is high the result waits and the block holds.
// Reset clears the matrix, restores the configuration defaults and idles.
module pagerank_power_iteration #(
  parameter int unsigned MAX_VERTICES = prpi_pkg::MaxVertices
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  prpi_pkg::req_t                req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_stall_i,
  output prpi_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [prpi_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned RW  = prpi_pkg::RankW;
  localparam int unsigned NV  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int unsigned VW  = 4;
  localparam int unsigned SW  = RW + 5;

  // configuration
  logic [4:0]  vcount_q;
  logic [15:0] null_q;
  logic [7:0]  iters_q;
  logic [15:0] damp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 5'd16;
      null_q   <= 16'd0;
      iters_q  <= 8'd100;
      damp_q   <= 16'd55706;
    end else if (cfg_we_i) begin
      unique case (prpi_pkg::cfg_idx_e'(cfg_idx_i))
        prpi_pkg::CfgVertexCount: vcount_q <= cfg_data_i[4:0];
        prpi_pkg::CfgNullEdge:    null_q   <= cfg_data_i;
        prpi_pkg::CfgIterCount:   iters_q  <= cfg_data_i[7:0];
        prpi_pkg::CfgDamping:     damp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // adjacency
  logic [15:0] adj_q [16];

  prpi_pkg::state_e state_q, state_d;
  logic req_acc;
  assign req_acc = req_valid_i && !req_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 16; r++) adj_q[r] <= '0;
    end else if (req_acc) begin
      if (req_i.action == prpi_pkg::ActClear) begin
        for (int r = 0; r < 16; r++) adj_q[r] <= '0;
      end else if (req_i.action == prpi_pkg::ActSetEdge &&
                   32'(req_i.from_index) < MAX_VERTICES &&
                   32'(req_i.to_index) < MAX_VERTICES) begin
        adj_q[req_i.from_index][req_i.to_index] <= (req_i.edge_weight != null_q);
      end
    end
  end

  // run control
  logic [4:0]  n_q;
  logic [4:0]  idx_q;
  logic [4:0]  cnt_q;
  logic [7:0]  it_q;
  logic [1:0]  sub_q;
  logic [4:0]  deg_q [16];
  logic [RW-1:0] tele_q, start_q;
  logic [RW-1:0] shload_q [16];
  logic        rsp_valid_q;
  logic        rsp_load;
  logic [RW:0] rnd;
  prpi_pkg::rsp_t rsp_q;

  // divider
  logic        div_start, div_busy;
  logic [47:0] div_num, div_quo;
  logic [23:0] div_den;

  prpi_div #(.NumW(48), .DenW(24)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  // cell ring
  prpi_pkg::cell_ctrl_t ctrl;
  logic [RW-1:0] share_w [16];
  logic [RW-1:0] rank_w  [16];
  logic [SW-1:0] sum_w   [16];
  logic [VW-1:0] src;
  logic [RW-1:0] newr_q  [16];
  logic          load_share;
  logic          commit_all;

  // The share at cell k after s shifts comes from vertex (k - s) mod 16.
  assign src = VW'(cnt_q);

  for (genvar k = 0; k < 16; k++) begin : g_cell
    logic [VW-1:0] from_v;
    logic          edge_on;
    assign from_v  = VW'(k) - src - 1'b1;
    assign edge_on = adj_q[from_v][k] && (5'(from_v) < n_q) && (5'(k) < n_q);
    prpi_cell u_cell (
      .clk_i,
      .ctrl_i      (ctrl),
      .init_rank_i (start_q),
      .new_rank_i  (newr_q[k]),
      .share_i     (share_w[(k + 15) % 16]),
      .share_load_i(shload_q[k]),
      .load_share_i(load_share),
      .edge_i      (edge_on),
      .share_o     (share_w[k]),
      .rank_o      (rank_w[k]),
      .sum_o       (sum_w[k])
    );
  end

  // per-vertex damped update uses one multiplier, registered
  logic [SW+15:0] prod_q;
  logic [SW+16:0] upd;

  always_comb begin
    upd = {22'd0, tele_q} + (({1'b0, prod_q} + 46'd32768) >> 16);
  end

  // state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prpi_pkg::StIdle:
        if (req_acc && req_i.action == prpi_pkg::ActRun) begin
          state_d = prpi_pkg::StDegree;
        end
      prpi_pkg::StDegree:
        if (n_q == '0) state_d = prpi_pkg::StIdle;
        else if (cnt_q == 5'(16)) state_d = prpi_pkg::StSetup;
      prpi_pkg::StSetup:
        if (sub_q == 2'd3 && !div_busy && !div_start) begin
          state_d = (iters_q == '0) ? prpi_pkg::StEmit : prpi_pkg::StIter;
        end
      prpi_pkg::StIter:
        if (sub_q == 2'd3 && it_q == iters_q) state_d = prpi_pkg::StEmit;
      prpi_pkg::StEmit:
        if (!rsp_valid_q || !rsp_stall_i) begin
          if (idx_q == n_q) state_d = prpi_pkg::StIdle;
        end
      default: state_d = prpi_pkg::StIdle;
    endcase
  end

  always_comb begin
    req_stall_o = (state_q != prpi_pkg::StIdle);
  end

  // Setup: sub 0 = 1/N, sub 1 = teleport, sub 3 = done.
  // Iter:  sub 0 = shares of each vertex (idx) and load, sub 1 = shift once around the 16-cell ring,
  //        sub 2 = per-vertex multiply/update, sub 3 = commit and next iteration.
  logic          div_pend_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == prpi_pkg::StSetup && !div_busy && !div_pend_q) begin
      unique case (sub_q)
        2'd0: begin
          div_start = 1'b1;
          div_num   = 48'(32'h800000 + 32'(n_q >> 1));
          div_den   = 24'(n_q);
        end
        2'd1: begin
          div_start = 1'b1;
          div_num   = (48'(17'h10000 - 17'(damp_q)) << 23) + 48'({n_q, 15'd0});
          div_den   = {3'd0, n_q, 16'd0};
        end
        default: ;
      endcase
    end else if (state_q == prpi_pkg::StIter && sub_q == 2'd0 && !div_busy &&
                 !div_pend_q && idx_q < n_q &&
                 deg_q[idx_q[VW-1:0]] != '0) begin
      div_start = 1'b1;
      div_num   = 48'(rank_w[idx_q[VW-1:0]]);
      div_den   = 24'(deg_q[idx_q[VW-1:0]]);
    end
  end

  assign commit_all  = (state_q == prpi_pkg::StIter) && sub_q == 2'd3;
  assign ctrl.init   = (state_q == prpi_pkg::StSetup) && sub_q == 2'd1 &&
                       div_pend_q && !div_busy;
  assign ctrl.shift  = (state_q == prpi_pkg::StIter) && sub_q == 2'd1;
  assign ctrl.commit = commit_all;
  assign load_share  = (state_q == prpi_pkg::StIter) && sub_q == 2'd0 &&
                       idx_q == n_q && !div_pend_q;

  assign rsp_load = (state_q == prpi_pkg::StEmit) && (!rsp_valid_q || !rsp_stall_i) &&
                    (idx_q != n_q);
  assign rnd      = {1'b0, rank_w[idx_q[VW-1:0]]} + (RW+1)'(64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prpi_pkg::StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      sub_q       <= '0;
      it_q        <= '0;
      n_q         <= '0;
      div_pend_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) div_pend_q <= 1'b1;
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (!rsp_stall_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        prpi_pkg::StIdle: begin
          cnt_q <= '0;
          idx_q <= '0;
          sub_q <= '0;
          it_q  <= '0;
          n_q   <= (vcount_q > 5'(NV)) ? 5'(NV) : vcount_q;
        end
        prpi_pkg::StDegree: begin
          if (cnt_q < 5'(16)) begin
            deg_q[cnt_q[3:0]] <= (cnt_q < n_q) ?
              5'($countones({1'b0, adj_q[cnt_q[3:0]]} & ((17'd1 << n_q) - 17'd1))) :
              '0;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            cnt_q <= '0;
          end
        end
        prpi_pkg::StSetup: begin
          if (div_pend_q && !div_busy && !div_start) begin
            div_pend_q <= 1'b0;
            if (sub_q == 2'd0) start_q <= div_quo[RW-1:0];
            if (sub_q == 2'd1) tele_q  <= div_quo[RW-1:0];
            sub_q <= (sub_q == 2'd1) ? 2'd3 : sub_q + 1'b1;
          end
          if (sub_q == 2'd3) begin
            sub_q <= '0;
            idx_q <= '0;
            it_q  <= 8'd1;
          end
        end
        prpi_pkg::StIter: begin
          unique case (sub_q)
            2'd0: begin
              if (div_pend_q && !div_busy && !div_start) begin
                div_pend_q                <= 1'b0;
                shload_q[idx_q[VW-1:0]]   <= div_quo[RW-1:0];
                idx_q                     <= idx_q + 1'b1;
              end else if (!div_pend_q && !div_start) begin
                if (idx_q == n_q) begin
                  sub_q <= 2'd1;
                  cnt_q <= '0;
                  idx_q <= '0;
                end else begin
                  shload_q[idx_q[VW-1:0]] <= '0;
                  idx_q <= idx_q + 1'b1;
                end
              end
            end
            2'd1: begin
              if (cnt_q == 5'd15) begin
                sub_q <= 2'd2;
                cnt_q <= '0;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
            2'd2: begin
              if (!cnt_q[0]) begin
                prod_q <= (SW+16)'(damp_q) * (SW+16)'(sum_w[idx_q[VW-1:0]]);
                cnt_q  <= 5'd1;
              end else begin
                newr_q[idx_q[VW-1:0]] <= (upd > (SW+17)'(prpi_pkg::RankMax)) ?
                                         prpi_pkg::RankMax : upd[RW-1:0];
                cnt_q <= '0;
                if (idx_q + 5'd1 == n_q) begin
                  sub_q <= 2'd3;
                  idx_q <= '0;
                end else begin
                  idx_q <= idx_q + 1'b1;
                end
              end
            end
            default: begin
              sub_q <= '0;
              idx_q <= '0;
              it_q  <= it_q + 1'b1;
            end
          endcase
        end
        prpi_pkg::StEmit: begin
          if (rsp_load) begin
            rsp_q.vertex_index <= idx_q[VW-1:0];
            rsp_q.rank_q16     <= (rnd[RW:RW-1] != 2'b00) ? 16'hFFFF : rnd[RW-2:7];
            rsp_q.last_rank    <= (idx_q + 5'd1 == n_q);
            idx_q              <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### hw/rtl/prpi_checker.sv
// Port-level checker for pagerank_power_iteration, bound to the top level.
// Depends on prpi_pkg.
module prpi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_stall_o,
  input prpi_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_stall_i,
  input prpi_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed while stalled");

  a_busy_on_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o)
    else $error("request taken while results pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_stall_i && rsp_o.last_rank |=> !rsp_valid_o)
    else $error("result after last rank");

  a_run_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o && req_i.action == prpi_pkg::ActRun |=> req_stall_o)
    else $error("run request did not stall the input");

endmodule

bind pagerank_power_iteration prpi_checker u_prpi_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i, .rsp_valid_o, .rsp_stall_i,
  .rsp_o
);
